[sv/dlr_pkg.sv]
// ----------------------------------------------------------------------------
// dlr_pkg: shared definitions for the DDA line rasterizer
// Field widths, register codes, reset values and the command and status
// groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package dlr_pkg;

   // Defaults for the top-level parameters.
   localparam int COORD_BITS_DEF = 12;
   localparam int FRAC_BITS_DEF  = 20;

   // Fixed field widths.
   localparam int WIN_W       = 12;
   localparam int ADDR_W      = 22;
   localparam int COLOR_W     = 32;
   localparam int CSR_INDEX_W = 4;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_WIDTH  = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_HEIGHT = 4'd1;

   // Register reset values.
   localparam logic [WIN_W-1:0] WIDTH_RESET  = 12'd800;
   localparam logic [WIN_W-1:0] HEIGHT_RESET = 12'd600;

   // Request action codes.
   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_STEP = 1'b1;

   typedef struct packed {
      logic load;     // latch endpoints, color and the start position
      logic prep;     // form the step count and start the dividers
      logic take;     // capture the signed increments
      logic advance;  // move both positions by one increment
      logic blank;    // a step with no line in progress
      logic round;    // round and clip the current position
      logic emit;     // load the result register
   } dlr_cmd_type;

   typedef struct packed {
      logic left_zero;
      logic n_zero;
      logic div_busy;
      logic out_free;
   } dlr_status_type;

endpackage

[sv/dlr_div.sv]
// ----------------------------------------------------------------------------
// dlr_div: restoring divider for the per-axis increment
// Produces one quotient bit per cycle. The numerator is known to give a
// quotient of at most FRAC_BITS+1 bits, so only those bits are iterated.
// ----------------------------------------------------------------------------
module dlr_div #(
   parameter int COORD_BITS = dlr_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = dlr_pkg::FRAC_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [COORD_BITS+FRAC_BITS:0]  numer,
   input  logic [COORD_BITS-1:0]          denom,
   output logic                           busy,
   output logic [FRAC_BITS:0]             quotient
);

   localparam int NUM_W = COORD_BITS + FRAC_BITS + 1;
   localparam int QW    = FRAC_BITS + 1;
   localparam int CNT_W = $clog2(QW + 1);

   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [COORD_BITS-1:0] rem_ff, rem_in;
   logic [QW-1:0]         lo_ff, lo_in;
   logic [COORD_BITS-1:0] den_ff, den_in;
   logic [COORD_BITS:0]   trial;
   logic [COORD_BITS:0]   diff;
   logic                  ge;

   assign trial = {rem_ff, lo_ff[QW-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign ge    = trial >= {1'b0, den_ff};

   always_comb begin
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      lo_in  = lo_ff;
      den_in = den_ff;
      if (start) begin
         cnt_in = CNT_W'(QW);
         rem_in = numer[NUM_W-1:QW];
         lo_in  = numer[QW-1:0];
         den_in = denom;
      end else if (busy) begin
         cnt_in = cnt_ff - 1'b1;
         rem_in = ge ? diff[COORD_BITS-1:0] : trial[COORD_BITS-1:0];
         // Quotient bits shift in behind the numerator bits as they leave.
         lo_in  = {lo_ff[QW-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      lo_ff  <= lo_in;
      den_ff <= den_in;
   end

   assign busy     = cnt_ff != '0;
   assign quotient = lo_ff;

endmodule

[sv/dlr_datapath.sv]
// ----------------------------------------------------------------------------
// dlr_datapath: line state, increment dividers, rounding and result register
// Holds the window registers, the fixed-point positions and increments,
// the remaining point count and the result register on the response side.
// ----------------------------------------------------------------------------
module dlr_datapath #(
   parameter int COORD_BITS = dlr_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = dlr_pkg::FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  dlr_pkg::dlr_cmd_type                cmd,
   output dlr_pkg::dlr_status_type             status,
   input  logic signed [COORD_BITS-1:0]        req_x_start,
   input  logic signed [COORD_BITS-1:0]        req_y_start,
   input  logic signed [COORD_BITS-1:0]        req_x_end,
   input  logic signed [COORD_BITS-1:0]        req_y_end,
   input  logic [dlr_pkg::COLOR_W-1:0]         req_pen_color,
   input  logic                                csr_write,
   input  logic [dlr_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [dlr_pkg::WIN_W-1:0]           csr_wdata,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic                                rsp_pixel_valid,
   output logic signed [COORD_BITS-1:0]        rsp_pixel_x,
   output logic signed [COORD_BITS-1:0]        rsp_pixel_y,
   output logic                                rsp_inside_window,
   output logic [dlr_pkg::ADDR_W-1:0]          rsp_pixel_address,
   output logic [dlr_pkg::COLOR_W-1:0]         rsp_out_color,
   output logic                                rsp_last
);

   localparam int C      = COORD_BITS;
   localparam int POS_W  = COORD_BITS + FRAC_BITS + 1;
   localparam int NUM_W  = COORD_BITS + FRAC_BITS + 1;
   localparam int QW     = FRAC_BITS + 1;
   localparam int SW     = FRAC_BITS + 2;
   localparam int WIN_W  = dlr_pkg::WIN_W;
   localparam int ADDR_W = dlr_pkg::ADDR_W;
   localparam int CMP_W  = (COORD_BITS > WIN_W) ? COORD_BITS : WIN_W;
   localparam int PROD_W = COORD_BITS + WIN_W;

   // Window registers.
   logic [WIN_W-1:0] width_ff, width_in;
   logic [WIN_W-1:0] height_ff, height_in;

   // Line state.
   logic [C:0]                    dx_ff, dx_in;
   logic [C:0]                    dy_ff, dy_in;
   logic [POS_W-1:0]              pos_x_ff, pos_x_in;
   logic [POS_W-1:0]              pos_y_ff, pos_y_in;
   logic [SW-1:0]                 step_x_ff, step_x_in;
   logic [SW-1:0]                 step_y_ff, step_y_in;
   logic [C-1:0]                  left_ff, left_in;
   logic [dlr_pkg::COLOR_W-1:0]   color_ff, color_in;
   logic                          blank_ff, blank_in;

   // Rounded point.
   logic [C-1:0] rx_ff, rx_in;
   logic [C-1:0] ry_ff, ry_in;
   logic         inside_ff, inside_in;

   // Result register.
   logic                          valid_ff, valid_in;
   logic                          pv_ff, pv_in;
   logic [C-1:0]                  px_ff, px_in;
   logic [C-1:0]                  py_ff, py_in;
   logic                          in_ff, in_in;
   logic [ADDR_W-1:0]             addr_ff, addr_in;
   logic [dlr_pkg::COLOR_W-1:0]   ocolor_ff, ocolor_in;
   logic                          last_ff, last_in;

   // Step count and divider operands.
   logic [C:0]       neg_dx, neg_dy;
   logic [C-1:0]     mag_x, mag_y, n_count;
   logic [NUM_W-1:0] numer_x, numer_y;
   logic             busy_x, busy_y;
   logic [QW-1:0]    quo_x, quo_y;
   logic [C:0]       round_x, round_y;
   logic [PROD_W-1:0] prod;
   logic [ADDR_W-1:0] addr_sum;

   function automatic logic [C:0] round_pos(input logic [POS_W-1:0] p);
      logic [POS_W-1:0] m;
      logic [POS_W-1:0] s;
      logic [C:0]       r;
      m = p[POS_W-1] ? (~p + 1'b1) : p;
      s = m + (POS_W'(1) << (FRAC_BITS - 1));
      r = s[FRAC_BITS +: C+1];
      return p[POS_W-1] ? (~r + 1'b1) : r;
   endfunction

   assign neg_dx  = ~dx_ff + 1'b1;
   assign neg_dy  = ~dy_ff + 1'b1;
   assign mag_x   = dx_ff[C] ? neg_dx[C-1:0] : dx_ff[C-1:0];
   assign mag_y   = dy_ff[C] ? neg_dy[C-1:0] : dy_ff[C-1:0];
   assign n_count = (mag_x >= mag_y) ? mag_x : mag_y;
   // Adding half the divisor first turns the floor division into rounding.
   assign numer_x = {1'b0, mag_x, {FRAC_BITS{1'b0}}} + NUM_W'(n_count >> 1);
   assign numer_y = {1'b0, mag_y, {FRAC_BITS{1'b0}}} + NUM_W'(n_count >> 1);

   dlr_div #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_div_x (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.prep && (n_count != '0)),
      .numer    (numer_x),
      .denom    (n_count),
      .busy     (busy_x),
      .quotient (quo_x)
   );

   dlr_div #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_div_y (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.prep && (n_count != '0)),
      .numer    (numer_y),
      .denom    (n_count),
      .busy     (busy_y),
      .quotient (quo_y)
   );

   assign round_x = round_pos(pos_x_ff);
   assign round_y = round_pos(pos_y_ff);

   assign prod     = PROD_W'(ry_ff) * PROD_W'(width_ff);
   assign addr_sum = ADDR_W'(prod) + ADDR_W'(rx_ff);

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write) begin
         unique case (csr_index)
            dlr_pkg::CSR_WINDOW_WIDTH:  width_in  = csr_wdata;
            dlr_pkg::CSR_WINDOW_HEIGHT: height_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      dx_in     = dx_ff;
      dy_in     = dy_ff;
      pos_x_in  = pos_x_ff;
      pos_y_in  = pos_y_ff;
      step_x_in = step_x_ff;
      step_y_in = step_y_ff;
      left_in   = left_ff;
      color_in  = color_ff;
      blank_in  = blank_ff;
      if (cmd.load) begin
         dx_in    = {req_x_end[C-1], req_x_end} - {req_x_start[C-1], req_x_start};
         dy_in    = {req_y_end[C-1], req_y_end} - {req_y_start[C-1], req_y_start};
         pos_x_in = {req_x_start[C-1], req_x_start, {FRAC_BITS{1'b0}}};
         pos_y_in = {req_y_start[C-1], req_y_start, {FRAC_BITS{1'b0}}};
         color_in = req_pen_color;
         blank_in = 1'b0;
      end
      if (cmd.prep) begin
         left_in   = n_count;
         step_x_in = '0;
         step_y_in = '0;
      end
      if (cmd.take) begin
         step_x_in = dx_ff[C] ? (~{1'b0, quo_x} + 1'b1) : {1'b0, quo_x};
         step_y_in = dy_ff[C] ? (~{1'b0, quo_y} + 1'b1) : {1'b0, quo_y};
      end
      if (cmd.advance) begin
         pos_x_in = pos_x_ff + {{(POS_W-SW){step_x_ff[SW-1]}}, step_x_ff};
         pos_y_in = pos_y_ff + {{(POS_W-SW){step_y_ff[SW-1]}}, step_y_ff};
         left_in  = left_ff - 1'b1;
         blank_in = 1'b0;
      end
      if (cmd.blank) begin
         blank_in = 1'b1;
      end
   end

   always_comb begin
      rx_in     = rx_ff;
      ry_in     = ry_ff;
      inside_in = inside_ff;
      if (cmd.round) begin
         rx_in     = round_x[C-1:0];
         ry_in     = round_y[C-1:0];
         inside_in = !round_x[C] && !round_y[C] &&
                     (CMP_W'(round_x[C-1:0]) < CMP_W'(width_ff)) &&
                     (CMP_W'(round_y[C-1:0]) < CMP_W'(height_ff));
      end
   end

   always_comb begin
      valid_in  = valid_ff;
      pv_in     = pv_ff;
      px_in     = px_ff;
      py_in     = py_ff;
      in_in     = in_ff;
      addr_in   = addr_ff;
      ocolor_in = ocolor_ff;
      last_in   = last_ff;
      if (rsp_ready) begin
         valid_in = 1'b0;
      end
      if (cmd.emit) begin
         valid_in = 1'b1;
         if (blank_ff) begin
            pv_in     = 1'b0;
            px_in     = '0;
            py_in     = '0;
            in_in     = 1'b0;
            addr_in   = '0;
            ocolor_in = '0;
            last_in   = 1'b0;
         end else begin
            pv_in     = 1'b1;
            px_in     = rx_ff;
            py_in     = ry_ff;
            in_in     = inside_ff;
            addr_in   = inside_ff ? addr_sum : '0;
            ocolor_in = color_ff;
            last_in   = left_ff == '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= dlr_pkg::WIDTH_RESET;
         height_ff <= dlr_pkg::HEIGHT_RESET;
         left_ff   <= '0;
         blank_ff  <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         left_ff   <= left_in;
         blank_ff  <= blank_in;
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dx_ff     <= dx_in;
      dy_ff     <= dy_in;
      pos_x_ff  <= pos_x_in;
      pos_y_ff  <= pos_y_in;
      step_x_ff <= step_x_in;
      step_y_ff <= step_y_in;
      color_ff  <= color_in;
      rx_ff     <= rx_in;
      ry_ff     <= ry_in;
      inside_ff <= inside_in;
      pv_ff     <= pv_in;
      px_ff     <= px_in;
      py_ff     <= py_in;
      in_ff     <= in_in;
      addr_ff   <= addr_in;
      ocolor_ff <= ocolor_in;
      last_ff   <= last_in;
   end

   assign status.left_zero = left_ff == '0;
   assign status.n_zero    = n_count == '0;
   assign status.div_busy  = busy_x || busy_y;
   assign status.out_free  = !valid_ff || rsp_ready;

   assign rsp_valid         = valid_ff;
   assign rsp_pixel_valid   = pv_ff;
   assign rsp_pixel_x       = px_ff;
   assign rsp_pixel_y       = py_ff;
   assign rsp_inside_window = in_ff;
   assign rsp_pixel_address = addr_ff;
   assign rsp_out_color     = ocolor_ff;
   assign rsp_last          = last_ff;

endmodule

[sv/dlr_ctrl.sv]
// ----------------------------------------------------------------------------
// dlr_ctrl: sequencer for the DDA line rasterizer
// Takes one request at a time and walks the datapath through setup,
// division, stepping, rounding and the hand-off to the result register.
// ----------------------------------------------------------------------------
module dlr_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_action,
   output logic                    req_ready,
   input  dlr_pkg::dlr_status_type status,
   output dlr_pkg::dlr_cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_PREP  = 3'd1;
   localparam logic [2:0] ST_DIV   = 3'd2;
   localparam logic [2:0] ST_ROUND = 3'd3;
   localparam logic [2:0] ST_EMIT  = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       accept;

   assign req_ready = state_ff == ST_IDLE;
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_action == dlr_pkg::ACT_LOAD) begin
                  cmd.load = 1'b1;
                  state_in = ST_PREP;
               end else if (status.left_zero) begin
                  cmd.blank = 1'b1;
                  state_in  = ST_EMIT;
               end else begin
                  cmd.advance = 1'b1;
                  state_in    = ST_ROUND;
               end
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            // A zero-length line keeps zero increments and skips the division.
            state_in = status.n_zero ? ST_ROUND : ST_DIV;
         end
         ST_DIV: begin
            if (!status.div_busy) begin
               cmd.take = 1'b1;
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            cmd.round = 1'b1;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[sv/dda_line_rasterizer_unit.sv]
// ----------------------------------------------------------------------------
// dda_line_rasterizer_unit: DDA line rasterizer
// A load request sets up a line and yields its first point; each step
// request while points remain yields the next rounded, window-checked point
// and, if inside, its framebuffer address; later steps yield no point.
//
//   Channel   Direction  Handshake             Payload
//   req_      in         req_valid/req_ready   action, endpoints, pen color
//   rsp_      out        rsp_valid/rsp_ready   point, inside flag, address,
//                                              color, last
//   csr_      in         csr_valid/csr_ready   register index, write data
//
// A step request passes through advance, round and emit to reach the result
// register; a step with no line in progress goes through blank and emit.
// A load runs setup, the one-bit-per-cycle restoring dividers that form
// the increments, round and emit; a zero-length line skips the division.
// The next request is accepted while a result waits in the result register;
// a stalled rsp_ready holds the engine only when a new result is ready.
// Reset is synchronous; the window registers come up as 800 by 600.
// ----------------------------------------------------------------------------
module dda_line_rasterizer_unit #(
   parameter int COORD_BITS = dlr_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = dlr_pkg::FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_action,
   input  logic signed [COORD_BITS-1:0]        req_x_start,
   input  logic signed [COORD_BITS-1:0]        req_y_start,
   input  logic signed [COORD_BITS-1:0]        req_x_end,
   input  logic signed [COORD_BITS-1:0]        req_y_end,
   input  logic [dlr_pkg::COLOR_W-1:0]         req_pen_color,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_pixel_valid,
   output logic signed [COORD_BITS-1:0]        rsp_pixel_x,
   output logic signed [COORD_BITS-1:0]        rsp_pixel_y,
   output logic                                rsp_inside_window,
   output logic [dlr_pkg::ADDR_W-1:0]          rsp_pixel_address,
   output logic [dlr_pkg::COLOR_W-1:0]         rsp_out_color,
   output logic                                rsp_last,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [dlr_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [dlr_pkg::WIN_W-1:0]           csr_wdata
);

   dlr_pkg::dlr_cmd_type    ctrl_cmd;
   dlr_pkg::dlr_status_type dp_status;

   assign csr_ready = 1'b1;

   dlr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_ready  (req_ready),
      .status     (dp_status),
      .cmd        (ctrl_cmd)
   );

   dlr_datapath #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (ctrl_cmd),
      .status            (dp_status),
      .req_x_start       (req_x_start),
      .req_y_start       (req_y_start),
      .req_x_end         (req_x_end),
      .req_y_end         (req_y_end),
      .req_pen_color     (req_pen_color),
      .csr_write         (csr_valid && csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .rsp_ready         (rsp_ready),
      .rsp_valid         (rsp_valid),
      .rsp_pixel_valid   (rsp_pixel_valid),
      .rsp_pixel_x       (rsp_pixel_x),
      .rsp_pixel_y       (rsp_pixel_y),
      .rsp_inside_window (rsp_inside_window),
      .rsp_pixel_address (rsp_pixel_address),
      .rsp_out_color     (rsp_out_color),
      .rsp_last          (rsp_last)
   );

   // A result without a point carries nothing else either.
   a_blank_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_pixel_valid |->
         rsp_pixel_x == '0 && rsp_pixel_y == '0 && !rsp_inside_window &&
         rsp_pixel_address == '0 && rsp_out_color == '0 && !rsp_last)
      else $error("blank result carries nonzero fields");

   a_outside_address: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_inside_window |-> rsp_pixel_address == '0)
      else $error("address set for a point outside the window");

   // The sequencer never overwrites a result that has not been taken.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ctrl_cmd.emit |-> dp_status.out_free)
      else $error("result register overwritten while still pending");

   // Only one transaction is in the engine at a time.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while another is in progress");

endmodule
